FILE: rtl/core/u8n1tx_pkg.sv
// Package for the 8N1 serial transmitter: item types, register indexes,
// frame phases and queue sizing. No dependencies.
package u8n1tx_pkg;

  // Input item as it arrives on the channel
  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_item_t;

  // Result item, one per input item
  typedef struct packed {
    logic tx_line;
    logic busy_res;
    logic load_accepted;
    logic holding_full;
  } out_item_t;

  // Operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Configuration register indexes and port sizing
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] REG_BIT_PERIOD      = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_DIVIDE_BY_EIGHT = 1'b1;

  localparam logic [CfgDataW-1:0] BitPeriodReset = 16'd104;

  // Frame sequencing
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_STOP  = 2'd3
  } phase_e;

  localparam logic [3:0] DataBits = 4'd8;

  // Classified command held in the queue between front and back
  typedef struct packed {
    logic       is_load;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

endpackage

FILE: rtl/core/u8n1tx_stream_if.sv
// Valid/ready channel carrying one item of type T.
// Used for both the input and the result channel; no dependencies.
interface u8n1tx_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/u8n1tx_front.sv
// Front end: takes input items and turns them into queue commands.
// Depends on u8n1tx_pkg and u8n1tx_stream_if.
module u8n1tx_front (
  u8n1tx_stream_if.sink          in_i,
  input  logic                   q_full_i,
  output u8n1tx_pkg::cmd_slot_t  push_o
);

  logic is_load;

  assign is_load    = (in_i.data.operation == u8n1tx_pkg::OP_LOAD);
  assign in_i.ready = ~q_full_i;

  always_comb begin
    push_o.valid         = in_i.valid & ~q_full_i;
    push_o.cmd.is_load   = is_load;
    // byte only matters on a load; ticks carry zero
    push_o.cmd.data_byte = is_load ? in_i.data.data_byte : 8'h00;
  end

endmodule

FILE: rtl/core/u8n1tx_queue.sv
// Short command queue between the front end and the frame engine.
// Depends on u8n1tx_pkg.
module u8n1tx_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  u8n1tx_pkg::cmd_slot_t  push_i,
  output logic                   full_o,
  output u8n1tx_pkg::cmd_slot_t  head_o,
  input  logic                   pop_i
);

  u8n1tx_pkg::cmd_t                    mem_q [u8n1tx_pkg::QueueDepth];
  logic [u8n1tx_pkg::QueuePtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [u8n1tx_pkg::QueuePtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [u8n1tx_pkg::QueueCntW-1:0]    count_q, count_d;
  logic                                do_push, do_pop;

  assign full_o       = (count_q == u8n1tx_pkg::QueueCntW'(u8n1tx_pkg::QueueDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  assign do_push = push_i.valid & ~full_o;
  assign do_pop  = pop_i & head_o.valid;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

FILE: rtl/core/u8n1tx_back.sv
// Frame engine: runs one queued command per cycle, unless out_o stalls,
// through the 8N1 framing state; holds the config and result registers.
// Depends on u8n1tx_pkg and u8n1tx_stream_if.
module u8n1tx_back #(
  parameter int unsigned PERIOD_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [u8n1tx_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [u8n1tx_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  u8n1tx_pkg::cmd_slot_t                head_i,
  output logic                                 pop_o,
  u8n1tx_stream_if.source                      out_o
);

  localparam int unsigned ExtW =
    (PERIOD_WIDTH > u8n1tx_pkg::CfgDataW) ? PERIOD_WIDTH : u8n1tx_pkg::CfgDataW;

  // configuration
  logic [u8n1tx_pkg::CfgDataW-1:0] bit_period_q;
  logic                            div8_q;

  // frame state
  u8n1tx_pkg::phase_e      phase_q, phase_d;
  logic [7:0]              shift_q, shift_d;
  logic [3:0]              bit_cnt_q, bit_cnt_d;
  logic [PERIOD_WIDTH-1:0] per_q, per_d;
  logic [2:0]              presc_q, presc_d;
  logic                    line_q, line_d;
  logic [7:0]              hold_byte_q, hold_byte_d;
  logic                    hold_valid_q, hold_valid_d;

  // result register
  logic                    out_valid_q, out_valid_d;
  u8n1tx_pkg::out_item_t   out_data_q, out_data_d;

  logic [ExtW-1:0]         bp_ext;
  logic [PERIOD_WIDTH-1:0] bp_cut;
  logic [PERIOD_WIDTH-1:0] limit;
  logic [PERIOD_WIDTH:0]   per_inc;
  logic                    accepted;
  logic                    tick_go;

  assign bp_ext  = ExtW'(bit_period_q);
  assign bp_cut  = bp_ext[PERIOD_WIDTH-1:0];
  assign limit   = (bp_cut == '0) ? PERIOD_WIDTH'(1) : bp_cut;
  assign per_inc = {1'b0, per_q} + (PERIOD_WIDTH + 1)'(1);

  assign pop_o     = head_i.valid & (~out_valid_q | out_o.ready);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_comb begin
    phase_d      = phase_q;
    shift_d      = shift_q;
    bit_cnt_d    = bit_cnt_q;
    per_d        = per_q;
    presc_d      = presc_q;
    line_d       = line_q;
    hold_byte_d  = hold_byte_q;
    hold_valid_d = hold_valid_q;
    accepted     = 1'b0;
    tick_go      = 1'b0;

    if (pop_o) begin
      if (!head_i.cmd.is_load) begin
        if (phase_q != u8n1tx_pkg::PH_IDLE) begin
          tick_go = 1'b1;
          if (div8_q) begin
            presc_d = presc_q + 3'd1;
            if (presc_d != 3'd0) begin
              tick_go = 1'b0;
            end
          end else begin
            presc_d = 3'd0;
          end
          if (tick_go) begin
            if (per_inc >= {1'b0, limit}) begin
              per_d = '0;
              // end of one serial bit
              case (phase_q)
                u8n1tx_pkg::PH_START: begin
                  phase_d   = u8n1tx_pkg::PH_DATA;
                  line_d    = shift_q[0];
                  shift_d   = {1'b0, shift_q[7:1]};
                  bit_cnt_d = bit_cnt_q + 4'd1;
                end
                u8n1tx_pkg::PH_DATA: begin
                  if (bit_cnt_q < u8n1tx_pkg::DataBits) begin
                    line_d    = shift_q[0];
                    shift_d   = {1'b0, shift_q[7:1]};
                    bit_cnt_d = bit_cnt_q + 4'd1;
                  end else begin
                    phase_d = u8n1tx_pkg::PH_STOP;
                    line_d  = 1'b1;
                  end
                end
                u8n1tx_pkg::PH_STOP: begin
                  bit_cnt_d = 4'd0;
                  presc_d   = 3'd0;
                  if (hold_valid_q) begin
                    // back-to-back frame from the holding register
                    hold_valid_d = 1'b0;
                    phase_d      = u8n1tx_pkg::PH_START;
                    shift_d      = hold_byte_q;
                    line_d       = 1'b0;
                  end else begin
                    phase_d = u8n1tx_pkg::PH_IDLE;
                    line_d  = 1'b1;
                  end
                end
                default: begin
                  phase_d = phase_q;
                end
              endcase
            end else begin
              per_d = per_inc[PERIOD_WIDTH-1:0];
            end
          end
        end
      end else if (!hold_valid_q) begin
        accepted = 1'b1;
        if (phase_q == u8n1tx_pkg::PH_IDLE) begin
          phase_d   = u8n1tx_pkg::PH_START;
          shift_d   = head_i.cmd.data_byte;
          bit_cnt_d = 4'd0;
          per_d     = '0;
          presc_d   = 3'd0;
          line_d    = 1'b0;
        end else begin
          hold_byte_d  = head_i.cmd.data_byte;
          hold_valid_d = 1'b1;
        end
      end
    end

    out_data_d.tx_line       = line_d;
    out_data_d.busy_res      = (phase_d != u8n1tx_pkg::PH_IDLE) | hold_valid_d;
    out_data_d.load_accepted = accepted;
    out_data_d.holding_full  = hold_valid_d;

    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q <= u8n1tx_pkg::BitPeriodReset;
      div8_q       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        u8n1tx_pkg::REG_BIT_PERIOD:      bit_period_q <= cfg_wdata_i;
        u8n1tx_pkg::REG_DIVIDE_BY_EIGHT: div8_q       <= cfg_wdata_i[0];
        default: begin
          div8_q <= div8_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= u8n1tx_pkg::PH_IDLE;
      shift_q      <= 8'h00;
      bit_cnt_q    <= 4'd0;
      per_q        <= '0;
      presc_q      <= 3'd0;
      line_q       <= 1'b1;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      shift_q      <= shift_d;
      bit_cnt_q    <= bit_cnt_d;
      per_q        <= per_d;
      presc_q      <= presc_d;
      line_q       <= line_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_byte_q <= hold_byte_d;
    if (pop_o) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

FILE: rtl/core/uart_8n1_transmitter_top.sv
// Channel      Dir  Modport  Payload
// in_i         in   sink     operation, data_byte (tick or byte load)
// out_o        out  source   tx_line, busy_res, load_accepted, holding_full
// cfg_*        in   -        write enable, register index, 16-bit data
//
// One item per clock sustained while out_o is ready; an accepted item is
// written to the queue, then popped into the result register once it is free.
// The 2-entry command queue decouples in_i from out_o; in_i.ready drops only
// when the queue is full because out_o is stalled.
// Reset clears the queue, frame state and result register; line idles high.
//
// Top level of the 8N1 transmitter: front end, command queue, frame engine.
// Depends on u8n1tx_pkg, u8n1tx_stream_if and the u8n1tx_* modules.
module uart_8n1_transmitter_top #(
  parameter int unsigned PERIOD_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [u8n1tx_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [u8n1tx_pkg::CfgDataW-1:0]  cfg_wdata_i,
  u8n1tx_stream_if.sink                    in_i,
  u8n1tx_stream_if.source                  out_o
);

  u8n1tx_pkg::cmd_slot_t push;
  u8n1tx_pkg::cmd_slot_t head;
  logic                  q_full;
  logic                  pop;

  u8n1tx_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  u8n1tx_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  u8n1tx_back #(
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

FILE: rtl/core/u8n1tx_checker.sv
// Port-level checks for the 8N1 transmitter, bound to the top level.
// Depends on uart_8n1_transmitter_top.
module u8n1tx_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic tx_line_i,
  input logic busy_res_i,
  input logic load_accepted_i,
  input logic holding_full_i
);

  // a waiting byte means the block is busy
  a_hold_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && holding_full_i |-> busy_res_i)
    else $error("holding_full without busy_res");

  // an idle block keeps the line high
  a_idle_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !busy_res_i |-> tx_line_i)
    else $error("line low while idle");

  // a load that starts a frame directly puts the start bit on the line
  a_start_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && load_accepted_i && !holding_full_i |-> !tx_line_i && busy_res_i)
    else $error("accepted load did not start a frame");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(tx_line_i)
      && $stable(busy_res_i) && $stable(load_accepted_i) && $stable(holding_full_i))
    else $error("result changed while stalled");

endmodule

bind uart_8n1_transmitter_top u8n1tx_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .tx_line_i       (out_o.data.tx_line),
  .busy_res_i      (out_o.data.busy_res),
  .load_accepted_i (out_o.data.load_accepted),
  .holding_full_i  (out_o.data.holding_full)
);

FILE: sim/uart_8n1_transmitter_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for uart_8n1_transmitter_top: directed table, then random
// tick/load streams under several bit periods. Depends on u8n1tx_pkg and u8n1tx_stream_if.
module uart_8n1_transmitter_top_tb;

  localparam int NumPhases = 12;
  localparam int NumRows   = 8;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                       kind;
    logic [u8n1tx_pkg::CfgIdxW-1:0]  idx;
    logic [u8n1tx_pkg::CfgDataW-1:0] val;
    int                              reps;
    u8n1tx_pkg::in_item_t            item;
    logic                            typed;
    u8n1tx_pkg::out_item_t           want;
  } dir_row_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [u8n1tx_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [u8n1tx_pkg::CfgDataW-1:0] cfg_wdata;

  u8n1tx_stream_if #(.T(u8n1tx_pkg::in_item_t))  in_if ();
  u8n1tx_stream_if #(.T(u8n1tx_pkg::out_item_t)) out_if ();

  uart_8n1_transmitter_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Directed stimulus; typed rows carry their own expected status
  dir_row_t dir_rows [NumRows] = '{
    '{ROW_ITEM, u8n1tx_pkg::REG_BIT_PERIOD, 16'd0, 1, '{u8n1tx_pkg::OP_TICK, 8'h00},
      1'b1, '{1'b1, 1'b0, 1'b0, 1'b0}},
    '{ROW_ITEM, u8n1tx_pkg::REG_BIT_PERIOD, 16'd0, 1, '{u8n1tx_pkg::OP_LOAD, 8'h00},
      1'b1, '{1'b0, 1'b1, 1'b1, 1'b0}},
    '{ROW_ITEM, u8n1tx_pkg::REG_BIT_PERIOD, 16'd0, 1, '{u8n1tx_pkg::OP_LOAD, 8'hff},
      1'b1, '{1'b0, 1'b1, 1'b1, 1'b1}},
    '{ROW_ITEM, u8n1tx_pkg::REG_BIT_PERIOD, 16'd0, 1, '{u8n1tx_pkg::OP_LOAD, 8'ha5},
      1'b1, '{1'b0, 1'b1, 1'b0, 1'b1}},
    '{ROW_ITEM, u8n1tx_pkg::REG_BIT_PERIOD, 16'd0, 1, '{u8n1tx_pkg::OP_TICK, 8'h3c},
      1'b0, '{1'b0, 1'b0, 1'b0, 1'b0}},
    // zero period acts as one tick per bit
    '{ROW_CFG,  u8n1tx_pkg::REG_BIT_PERIOD, 16'd0, 0, '{u8n1tx_pkg::OP_TICK, 8'h00},
      1'b0, '{1'b0, 1'b0, 1'b0, 1'b0}},
    '{ROW_ITEM, u8n1tx_pkg::REG_BIT_PERIOD, 16'd0, 20, '{u8n1tx_pkg::OP_TICK, 8'h5a},
      1'b0, '{1'b0, 1'b0, 1'b0, 1'b0}},
    '{ROW_ITEM, u8n1tx_pkg::REG_BIT_PERIOD, 16'd0, 1, '{u8n1tx_pkg::OP_TICK, 8'h00},
      1'b1, '{1'b1, 1'b0, 1'b0, 1'b0}}
  };

  // Predictor state
  u8n1tx_pkg::phase_e tx_phase;
  logic [7:0]         tx_shift;
  logic [3:0]         tx_bits;
  logic [15:0]        tx_period_cnt;
  logic [2:0]         tx_prescale;
  logic               tx_level;
  logic [7:0]         hold_byte;
  logic               hold_valid;
  logic [15:0]        bit_period_reg;
  logic               div8_reg;

  u8n1tx_pkg::out_item_t pending_status_q [$];
  int                    mismatch_count = 0;
  int                    src_gap_max    = 12;
  int                    snk_gap_max    = 12;

  initial begin
    clk_i     = 1'b0;
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
  end

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("uart_8n1_transmitter_top_tb failed");
    $finish;
  end

  task automatic start_frame(input logic [7:0] b);
    tx_phase      = u8n1tx_pkg::PH_START;
    tx_shift      = b;
    tx_bits       = '0;
    tx_period_cnt = '0;
    tx_prescale   = '0;
    tx_level      = 1'b0;
  endtask

  task automatic predict_tx_status(input u8n1tx_pkg::in_item_t it,
                                   output u8n1tx_pkg::out_item_t res);
    logic        taken;
    logic        strobe;
    logic [16:0] limit;
    taken = 1'b0;
    if (it.operation == u8n1tx_pkg::OP_TICK) begin
      if (tx_phase != u8n1tx_pkg::PH_IDLE) begin
        strobe = 1'b1;
        if (div8_reg) begin
          tx_prescale = tx_prescale + 3'd1;
          strobe = (tx_prescale == 3'd0);
        end else begin
          tx_prescale = '0;
        end
        if (strobe) begin
          limit = (bit_period_reg == 16'd0) ? 17'd1 : {1'b0, bit_period_reg};
          if ({1'b0, tx_period_cnt} + 17'd1 >= limit) begin
            tx_period_cnt = '0;
            if (tx_phase == u8n1tx_pkg::PH_START ||
                (tx_phase == u8n1tx_pkg::PH_DATA && tx_bits < u8n1tx_pkg::DataBits)) begin
              tx_phase = u8n1tx_pkg::PH_DATA;
              tx_level = tx_shift[0];
              tx_shift = tx_shift >> 1;
              tx_bits  = tx_bits + 4'd1;
            end else if (tx_phase == u8n1tx_pkg::PH_DATA) begin
              tx_phase = u8n1tx_pkg::PH_STOP;
              tx_level = 1'b1;
            end else if (hold_valid) begin
              // back-to-back frame from the holding register
              hold_valid = 1'b0;
              start_frame(hold_byte);
            end else begin
              tx_phase    = u8n1tx_pkg::PH_IDLE;
              tx_level    = 1'b1;
              tx_bits     = '0;
              tx_prescale = '0;
            end
          end else begin
            tx_period_cnt = tx_period_cnt + 16'd1;
          end
        end
      end
    end else if (tx_phase == u8n1tx_pkg::PH_IDLE && !hold_valid) begin
      start_frame(it.data_byte);
      taken = 1'b1;
    end else if (!hold_valid) begin
      hold_byte  = it.data_byte;
      hold_valid = 1'b1;
      taken      = 1'b1;
    end
    res.tx_line       = tx_level;
    res.busy_res      = (tx_phase != u8n1tx_pkg::PH_IDLE) || hold_valid;
    res.load_accepted = taken;
    res.holding_full  = hold_valid;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [u8n1tx_pkg::CfgIdxW-1:0] idx,
                           input logic [u8n1tx_pkg::CfgDataW-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == u8n1tx_pkg::REG_BIT_PERIOD) bit_period_reg = val;
    else div8_reg = val[0];
    @(posedge clk_i);
  endtask

  // Called at a clock edge; leaves valid high after the handshake
  task automatic send_item(input u8n1tx_pkg::in_item_t it, input int gap, input logic typed,
                           input u8n1tx_pkg::out_item_t want);
    u8n1tx_pkg::out_item_t pred;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_tx_status(it, pred);
    pending_status_q.push_back(typed ? want : pred);
  endtask

  task automatic check_field(input string name, input logic exp_v, input logic act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %b, actual %b", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Result side: random stalls plus one long hold-off to back up the queue
  initial begin
    int                    gap;
    int                    rx_count;
    logic                  held_off;
    u8n1tx_pkg::out_item_t got;
    u8n1tx_pkg::out_item_t exp_s;
    rx_count = 0;
    held_off = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = $urandom_range(0, snk_gap_max);
      if (!held_off && rx_count == 300) begin
        gap      = 300;
        held_off = 1'b1;
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      got = out_if.data;
      rx_count++;
      if (pending_status_q.size() == 0) begin
        $display("%0t: result with no item pending, actual %p", $time, got);
        mismatch_count++;
      end else begin
        exp_s = pending_status_q.pop_front();
        check_field("tx_line", exp_s.tx_line, got.tx_line);
        check_field("busy_res", exp_s.busy_res, got.busy_res);
        check_field("load_accepted", exp_s.load_accepted, got.load_accepted);
        check_field("holding_full", exp_s.holding_full, got.holding_full);
      end
    end
  end

  initial begin
    int                    p;
    int                    n;
    int                    r;
    int                    load_w;
    int                    n_items;
    logic [15:0]           bp_next;
    logic                  d8_next;
    u8n1tx_pkg::in_item_t  it;
    u8n1tx_pkg::out_item_t none;

    none           = '0;
    tx_phase       = u8n1tx_pkg::PH_IDLE;
    tx_shift       = '0;
    tx_bits        = '0;
    tx_period_cnt  = '0;
    tx_prescale    = '0;
    tx_level       = 1'b1;
    hold_byte      = '0;
    hold_valid     = 1'b0;
    bit_period_reg = u8n1tx_pkg::BitPeriodReset;
    div8_reg       = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < NumRows; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        write_reg(dir_rows[r].idx, dir_rows[r].val);
      end else begin
        for (n = 0; n < dir_rows[r].reps; n++)
          send_item(dir_rows[r].item, $urandom_range(0, src_gap_max), dir_rows[r].typed,
                    dir_rows[r].want);
      end
    end

    for (p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin bp_next = 16'd1;     d8_next = 1'b0; end
        1: begin bp_next = 16'd2;     d8_next = 1'b1; end
        2: begin bp_next = 16'hffff;  d8_next = 1'b1; end
        3: begin bp_next = 16'd1;     d8_next = 1'b1; end
        4: begin bp_next = 16'd3;     d8_next = 1'b0; end
        5: begin bp_next = 16'd0;     d8_next = 1'b0; end
        6: begin bp_next = 16'hffff;  d8_next = 1'b0; end
        default: begin
          bp_next = 16'($urandom_range(1, 4));
          d8_next = 1'($urandom_range(0, 1));
        end
      endcase
      write_reg(u8n1tx_pkg::REG_BIT_PERIOD, bp_next);
      write_reg(u8n1tx_pkg::REG_DIVIDE_BY_EIGHT, {15'd0, d8_next});
      // every third phase runs with no idling on either side
      src_gap_max = (p % 3 == 0) ? 0 : 12;
      snk_gap_max = (p % 3 == 0) ? 0 : 12;
      load_w  = $urandom_range(1, 4);
      n_items = (bp_next > 16'd16) ? 40 : 160;
      for (n = 0; n < n_items; n++) begin
        if (p == 4 && n == 80) wait_drained();
        it.operation = ($urandom_range(0, 15) < load_w) ? u8n1tx_pkg::OP_LOAD
                                                        : u8n1tx_pkg::OP_TICK;
        it.data_byte = 8'($urandom_range(0, 255));
        send_item(it, $urandom_range(0, src_gap_max), 1'b0, none);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_status_q.size() == 0) begin
      $display("uart_8n1_transmitter_top_tb passed");
    end else begin
      $display("uart_8n1_transmitter_top_tb failed");
    end
    $finish;
  end

endmodule
